// File: rtl/tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the text field/column selector.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int unsigned SEL_REGS        = 6;
    localparam int unsigned RANGE_COUNT_DEF = 6;
    localparam int unsigned POS_W           = 16;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned RANGE_W         = 32;
    localparam int unsigned CFG_IDX_W       = 3;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE   = 8'd10;
    localparam logic [BYTE_W-1:0] DELIM_RESET    = 8'd9;
    localparam logic [POS_W-1:0]  POS_FIRST      = 16'd1;
    localparam logic [POS_W-1:0]  POS_MAX        = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_DELIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_BASE  = 3'd2;

    localparam logic MODE_FIELD = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    typedef logic [SEL_REGS-1:0][RANGE_W-1:0] range_set_t;

    typedef struct packed {
        logic              select_mode;
        logic [BYTE_W-1:0] field_delimiter;
        range_set_t        ranges;
    } tcs_cfg_t;

endpackage

// File: rtl/tcs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_cfg_regs
// Configuration register file: mode, delimiter and six range words.
// ----------------------------------------------------------------------------
module tcs_cfg_regs
    import tcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data,
    output tcs_cfg_t             cfg
);

    tcs_cfg_t cfg_reg;
    tcs_cfg_t cfg_next;
    logic [CFG_IDX_W-1:0] range_idx;

    assign range_idx = cfg_index - REG_RANGE_BASE;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            if (cfg_index == REG_SELECT_MODE) begin
                cfg_next.select_mode = cfg_data[0];
            end else if (cfg_index == REG_FIELD_DELIM) begin
                cfg_next.field_delimiter = cfg_data[BYTE_W-1:0];
            end else begin
                cfg_next.ranges[range_idx] = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.select_mode     <= MODE_FIELD;
            cfg_reg.field_delimiter <= DELIM_RESET;
            cfg_reg.ranges          <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tcs_range_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_range_match
// Checks one position against the active ranges in parallel.
// ----------------------------------------------------------------------------
module tcs_range_match
    import tcs_pkg::*;
#(
    parameter int unsigned RANGE_COUNT = RANGE_COUNT_DEF
) (
    input  logic [POS_W-1:0] pos,
    input  range_set_t       ranges,
    output logic             hit
);

    logic [RANGE_COUNT-1:0] hits;

    always_comb begin
        for (int k = 0; k < RANGE_COUNT; k++) begin
            hits[k] = (ranges[k][RANGE_W-1:POS_W] != '0)
                   && (pos >= ranges[k][RANGE_W-1:POS_W])
                   && (pos <= ranges[k][POS_W-1:0]);
        end
    end

    assign hit = |hits;

endmodule

// File: rtl/text_field_column_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_field_column_selector
// Streaming cut-style selector: passes bytes of selected fields or positions.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   s_      | s_valid, s_ready, s_text_byte[7:0]       | in
//   m_      | m_valid, m_ready, m_out_byte[7:0]        | out
//   cfg_    | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One word accepted per cycle while the output is not stalled; each word yields
// zero or one output word. Each word passes the input register, then selection
// logic into the output register, which drives m_valid.
// Words that produce no output retire without waiting on m_ready.
// Synchronous active-low reset clears line state and configuration.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module text_field_column_selector
    import tcs_pkg::*;
#(
    parameter int unsigned RANGE_COUNT = RANGE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_text_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data
);

    tcs_cfg_t cfg;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              earlier_reg, earlier_next;

    logic [POS_W-1:0]  pos_adv;
    logic              cur_sel, adv_sel;
    logic              is_nl, is_delim, emit, process;

    assign cfg_ready = 1'b1;

    tcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign pos_adv = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_FIRST;

    tcs_range_match #(.RANGE_COUNT(RANGE_COUNT)) u_match_cur (
        .pos    (pos_reg),
        .ranges (cfg.ranges),
        .hit    (cur_sel)
    );

    tcs_range_match #(.RANGE_COUNT(RANGE_COUNT)) u_match_adv (
        .pos    (pos_adv),
        .ranges (cfg.ranges),
        .hit    (adv_sel)
    );

    assign is_nl    = (in_byte_reg == NEWLINE_BYTE);
    assign is_delim = (in_byte_reg == cfg.field_delimiter);

    always_comb begin
        pos_next     = pos_reg;
        earlier_next = earlier_reg;
        emit         = 1'b0;
        if (is_nl) begin
            pos_next     = POS_FIRST;
            earlier_next = 1'b0;
            emit         = 1'b1;
        end else if (cfg.select_mode == MODE_BYTE) begin
            pos_next = pos_adv;
            emit     = cur_sel;
        end else if (is_delim) begin
            earlier_next = earlier_reg | cur_sel;
            pos_next     = pos_adv;
            emit         = adv_sel & earlier_next;
        end else begin
            emit = cur_sel;
        end
    end

    assign process = in_valid_reg && (!out_valid_reg || m_ready || !emit);
    assign s_ready = !in_valid_reg || process;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (process && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_FIRST;
            earlier_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process) begin
                pos_reg     <= pos_next;
                earlier_reg <= earlier_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
        if (process && emit) begin
            out_byte_reg <= in_byte_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;

    // position counter never reaches zero
    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != '0)
        else $error("position counter is zero");

    // newline always restarts the line and is passed
    a_nl_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        process && is_nl |=> pos_reg == POS_FIRST && !earlier_reg
                             && m_valid && m_out_byte == NEWLINE_BYTE)
        else $error("newline did not restart line");

    // an emitting word never overwrites a pending output word
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        process && emit |-> !out_valid_reg || m_ready)
        else $error("output word overwritten");

    // a non-delimiter word in field mode leaves the counter unchanged
    a_field_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        process && !is_nl && !is_delim && cfg.select_mode == MODE_FIELD
        |=> $stable(pos_reg))
        else $error("field counter moved on ordinary byte");

    // input register is empty and m_valid is low in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !m_valid)
        else $error("pipeline not empty after reset");

endmodule

// File: tb/tb_text_field_column_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_field_column_selector
// Self-checking bench for the cut-style field/byte selector.
//
// Drives text bytes over the s_ channel, random register settings over cfg_,
// and compares every m_ word with a cycle-free model of the selection
// (line position counter, per-line "earlier field selected" flag, six
// ranges). Directed lines first, then random phases, most with random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_text_field_column_selector;
    import tcs_pkg::*;

    typedef logic [BYTE_W-1:0]    text_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [RANGE_W-1:0]   range_word_t;
    typedef logic [CFG_IDX_W-1:0] reg_idx_t;

    localparam int unsigned RUN_LIMIT    = 1_000_000;
    localparam int unsigned DRAIN_SLACK  = 4;
    localparam int unsigned RAND_PHASES  = 10;
    localparam int unsigned PHASE_WORDS  = 170;

    class selected_byte_scoreboard;
        logic        mode;
        text_t       delim;
        range_word_t ranges[SEL_REGS];
        pos_t        pos;
        bit          earlier;
        text_t       selected_bytes[$];
        int          errors;

        function new();
            mode    = MODE_FIELD;
            delim   = DELIM_RESET;
            pos     = POS_FIRST;
            earlier = 1'b0;
            errors  = 0;
            foreach (ranges[k]) ranges[k] = '0;
        endfunction

        function void take_config(reg_idx_t idx, range_word_t data);
            if (idx == REG_SELECT_MODE) begin
                mode = data[0];
            end else if (idx == REG_FIELD_DELIM) begin
                delim = data[BYTE_W-1:0];
            end else if (idx >= REG_RANGE_BASE && (idx - REG_RANGE_BASE) < SEL_REGS) begin
                ranges[idx - REG_RANGE_BASE] = data;
            end
        endfunction

        function bit position_selected(pos_t p);
            pos_t lo;
            pos_t hi;
            for (int k = 0; k < RANGE_COUNT_DEF && k < SEL_REGS; k++) begin
                lo = ranges[k][RANGE_W-1:POS_W];
                hi = ranges[k][POS_W-1:0];
                if (lo != '0 && p >= lo && p <= hi) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void bump_position();
            if (pos != POS_MAX) pos = pos + 1'b1;
        endfunction

        function void take_text_byte(text_t b);
            bit sel;
            if (b == NEWLINE_BYTE) begin
                pos     = POS_FIRST;
                earlier = 1'b0;
                selected_bytes.push_back(NEWLINE_BYTE);
            end else if (mode == MODE_BYTE) begin
                sel = position_selected(pos);
                bump_position();
                if (sel) selected_bytes.push_back(b);
            end else if (b == delim) begin
                if (position_selected(pos)) earlier = 1'b1;
                bump_position();
                if (position_selected(pos) && earlier) selected_bytes.push_back(b);
            end else if (position_selected(pos)) begin
                selected_bytes.push_back(b);
            end
        endfunction

        function void check_out_byte(text_t b);
            text_t want;
            if (selected_bytes.size() == 0) begin
                $error("out_byte: expected none, actual 0x%02h", b);
                errors++;
            end else begin
                want = selected_bytes.pop_front();
                if (want !== b) begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", want, b);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return selected_bytes.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    text_t       s_text_byte;
    logic        m_valid;
    logic        m_ready;
    text_t       m_out_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    reg_idx_t    cfg_index;
    range_word_t cfg_data;

    selected_byte_scoreboard sb;
    range_word_t             next_ranges[SEL_REGS];
    bit                      tx_gaps_on;
    bit                      rx_stalls_on;
    int unsigned             rx_stall_left;
    int unsigned             cycle_count;

    text_field_column_selector u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_out_byte(m_out_byte);
    end

    // receiver back-pressure: random stall bursts while enabled
    always @(negedge aclk) begin
        if (rx_stall_left == 0 && rx_stalls_on && $urandom_range(0, 9) == 0)
            rx_stall_left = $urandom_range(1, 11);
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic text_t random_text_byte();
        text_t b;
        b = text_t'($urandom_range(0, 255));
        if (b == NEWLINE_BYTE) b = b ^ 8'h01;
        return b;
    endfunction

    function automatic range_word_t random_range_word();
        pos_t lo;
        pos_t hi;
        case ($urandom_range(0, 6))
            0: return '0;
            1: return range_word_t'($urandom);
            2: begin
                lo = pos_t'($urandom_range(1, 8));
                hi = lo + pos_t'($urandom_range(0, 6));
            end
            3: begin
                lo = pos_t'($urandom_range(1, 12));
                hi = POS_MAX;
            end
            4: begin
                lo = pos_t'($urandom_range(3, 10));
                hi = pos_t'($urandom_range(1, lo - 1));
            end
            5: begin
                lo = '0;
                hi = pos_t'($urandom);
            end
            default: begin
                lo = pos_t'($urandom_range(1, 20));
                hi = pos_t'($urandom_range(1, 24));
            end
        endcase
        return {lo, hi};
    endfunction

    function automatic text_t random_delimiter();
        case ($urandom_range(0, 5))
            0: return DELIM_RESET;
            1: return NEWLINE_BYTE;
            2: return 8'h00;
            3: return 8'hFF;
            default: return text_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_text(input text_t b);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_text_byte(b);
    endtask

    // stop sending, wait for every expected word, then let the pipe settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input range_word_t data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.take_config(idx, data);
    endtask

    task automatic apply_config(input logic mode, input text_t delim);
        write_reg(REG_SELECT_MODE, {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, mode});
        write_reg(REG_FIELD_DELIM, {24'($urandom), delim});
        for (int k = 0; k < SEL_REGS; k++)
            write_reg(REG_RANGE_BASE + reg_idx_t'(k), next_ranges[k]);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_line(input text_t bytes[$]);
        foreach (bytes[i]) send_text(bytes[i]);
    endtask

    task automatic random_phase(input int unsigned words);
        int unsigned sent;
        int unsigned line_words;
        text_t       b;
        sent = 0;
        while (sent < words) begin
            line_words = $urandom_range(0, 20);
            for (int unsigned i = 0; i < line_words; i++) begin
                if (sb.mode == MODE_FIELD && $urandom_range(0, 3) == 0) b = sb.delim;
                else if ($urandom_range(0, 29) == 0) b = NEWLINE_BYTE;
                else b = random_text_byte();
                send_text(b);
            end
            if ($urandom_range(0, 9) != 0) send_text(NEWLINE_BYTE);
            sent += line_words + 1;
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_text_byte   = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        rx_stall_left = 0;
        cycle_count   = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: field mode, tab, nothing selected, newline only
        send_line('{8'h00, 8'hFF, DELIM_RESET, NEWLINE_BYTE});
        drain();

        // fields 2..3 and 5 onward; reversed, low-zero and top-of-range entries
        next_ranges = '{{16'd2, 16'd3}, {16'd5, POS_MAX}, {16'd7, 16'd4},
                        {16'd0, POS_MAX}, 32'hFFFF_FFFF, 32'h0};
        apply_config(MODE_FIELD, DELIM_RESET);
        send_line('{8'h41, DELIM_RESET, 8'h42, DELIM_RESET, 8'h43, DELIM_RESET,
                    8'h44, DELIM_RESET, DELIM_RESET, 8'h46, DELIM_RESET, 8'hFF,
                    NEWLINE_BYTE});
        drain();

        // newline wins over a newline delimiter
        next_ranges = '{{16'd1, 16'd2}, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        apply_config(MODE_FIELD, NEWLINE_BYTE);
        send_line('{8'h78, NEWLINE_BYTE, 8'h7A});
        drain();

        // byte mode ignores the delimiter
        next_ranges = '{{16'd1, 16'd1}, {16'd3, 16'd4}, 32'h0, 32'h0, 32'h0, 32'h0};
        apply_config(MODE_BYTE, 8'h00);
        send_line('{8'hFF, 8'h00, 8'h00, 8'h80, 8'h01, NEWLINE_BYTE});
        drain();

        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            tx_gaps_on   = (ph < RAND_PHASES - 2) && (ph % 3 != 2);
            rx_stalls_on = (ph < RAND_PHASES - 2) && (ph % 4 != 3);
            foreach (next_ranges[k]) next_ranges[k] = random_range_word();
            apply_config(ph % 2 ? MODE_BYTE : MODE_FIELD, random_delimiter());
            random_phase(PHASE_WORDS / 2);
            if (ph == 3) drain();
            random_phase(PHASE_WORDS / 2);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
